// ===== rtl/button_gesture_classifier_top_macros.svh =====
// Assertion helpers used by the top-level RTL file.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BGC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/bgc_pkg.sv =====
package bgc_pkg;

  // Timer width of the hold and release timers
  localparam int unsigned TIME_BITS = 16;
  // Width of each configuration register
  localparam int unsigned CFG_BITS = 16;
  // Compare width that holds both a timer and a threshold without loss
  localparam int unsigned CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_POWER_LONG = 2'd0,
    REG_MODE_LONG  = 2'd1,
    REG_MIN_CLICK  = 2'd2,
    REG_DBL_WINDOW = 2'd3
  } cfg_reg_e;

  // Register reset values
  localparam logic [CFG_BITS-1:0] POWER_LONG_RST = CFG_BITS'(2000);
  localparam logic [CFG_BITS-1:0] MODE_LONG_RST  = CFG_BITS'(1500);
  localparam logic [CFG_BITS-1:0] MIN_CLICK_RST  = CFG_BITS'(50);
  localparam logic [CFG_BITS-1:0] DBL_WINDOW_RST = CFG_BITS'(350);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_BITS-1:0]  cfg_t;

  // Per-button events for one tick
  typedef struct packed {
    logic start;
    logic lng;
    logic qual;
  } btn_ev_t;

  // Saturating increment of a timer
  function automatic time_t sat_inc(input time_t t);
    sat_inc = (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic logic [CMP_BITS-1:0] ext_time(input time_t t);
    ext_time = CMP_BITS'(t);
  endfunction

  function automatic logic [CMP_BITS-1:0] ext_cfg(input cfg_t c);
    ext_cfg = CMP_BITS'(c);
  endfunction

endpackage

// ===== rtl/bgc_button.sv =====
module bgc_button (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             down_i,
  input  bgc_pkg::cfg_t    long_ms_i,
  input  bgc_pkg::cfg_t    min_click_ms_i,
  output bgc_pkg::btn_ev_t ev_o
);
  import bgc_pkg::*;

  logic  held_q, held_d;
  logic  done_q, done_d;
  time_t hold_q, hold_d;
  time_t hold_inc;

  assign hold_inc = sat_inc(hold_q);

  // Classify this tick from the level and the held state
  always_comb begin
    ev_o   = '0;
    held_d = held_q;
    done_d = done_q;
    hold_d = hold_q;
    if (down_i && !held_q) begin
      held_d    = 1'b1;
      done_d    = 1'b0;
      hold_d    = '0;
      ev_o.start = 1'b1;
    end else if (down_i && held_q) begin
      hold_d = hold_inc;
      if (!done_q && (ext_time(hold_inc) >= ext_cfg(long_ms_i))) begin
        done_d   = 1'b1;
        ev_o.lng = 1'b1;
      end
    end else if (!down_i && held_q) begin
      held_d = 1'b0;
      hold_d = hold_inc;
      ev_o.qual = !done_q &&
                  (ext_time(hold_inc) > ext_cfg(min_click_ms_i)) &&
                  (ext_time(hold_inc) < ext_cfg(long_ms_i));
    end
  end

  // Advance button state once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      done_q <= 1'b0;
      hold_q <= '0;
    end else if (adv_i) begin
      held_q <= held_d;
      done_q <= done_d;
      hold_q <= hold_d;
    end
  end

endmodule

// ===== rtl/bgc_click.sv =====
module bgc_click (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  bgc_pkg::btn_ev_t pwr_ev_i,
  input  bgc_pkg::cfg_t    dbl_window_ms_i,
  output logic             double_o,
  output logic             single_o
);
  import bgc_pkg::*;

  logic [1:0] tally_q, tally_d;
  time_t      since_q, since_d;

  // Count qualifying clicks, clear the count on a long press, and time out a lone click
  always_comb begin
    double_o = 1'b0;
    single_o = 1'b0;
    tally_d  = tally_q;
    since_d  = sat_inc(since_q);
    if (pwr_ev_i.lng) begin
      tally_d = '0;
    end
    if (pwr_ev_i.qual) begin
      tally_d = tally_d + 2'd1;
      since_d = '0;
      if (tally_d == 2'd2) begin
        tally_d  = '0;
        double_o = 1'b1;
      end
    end
    if ((tally_d == 2'd1) && (ext_time(since_d) > ext_cfg(dbl_window_ms_i))) begin
      tally_d  = '0;
      single_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      since_q <= '0;
    end else if (adv_i) begin
      tally_q <= tally_d;
      since_q <= since_d;
    end
  end

endmodule

// ===== rtl/button_gesture_classifier_top.sv =====
// An input transaction reaches its earliest result transaction through the input register
// and then the result register. Throughput: one item per cycle while m_axis_tready
// stays high; while a result waits, the input register takes one more item and then
// s_axis_tready drops until the result is taken.
// Reset: rst_ni clears all button and click state, empties both stages and
// restores the configuration registers to 2000, 1500, 50 and 350 ms.
`include "button_gesture_classifier_top_macros.svh"

module button_gesture_classifier_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [15:0]            cfg_data_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [0] power_down, [1] mode_down
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] power_press_start, [1] mode_press_start, [2] power_long,
  // [3] power_double, [4] power_single, [5] mode_long, [6] mode_short
  output logic [7:0]             m_axis_tdata
);
  import bgc_pkg::*;

  cfg_t power_long_q, mode_long_q, min_click_q, dbl_window_q;

  logic s1_valid_q, s1_pwr_q, s1_mode_q;
  logic out_valid_q;
  logic [6:0] res_q, res_d;
  logic out_ready, adv;

  btn_ev_t pwr_ev, mode_ev;
  logic    pdouble, psingle;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_long_q <= POWER_LONG_RST;
      mode_long_q  <= MODE_LONG_RST;
      min_click_q  <= MIN_CLICK_RST;
      dbl_window_q <= DBL_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POWER_LONG: power_long_q <= cfg_data_i;
        REG_MODE_LONG:  mode_long_q  <= cfg_data_i;
        REG_MIN_CLICK:  min_click_q  <= cfg_data_i;
        REG_DBL_WINDOW: dbl_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign adv           = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_pwr_q  <= s_axis_tdata[0];
      s1_mode_q <= s_axis_tdata[1];
    end
  end

  bgc_button u_pwr (
    .clk_i,
    .rst_ni,
    .adv_i          (adv),
    .down_i         (s1_pwr_q),
    .long_ms_i      (power_long_q),
    .min_click_ms_i (min_click_q),
    .ev_o           (pwr_ev)
  );

  bgc_button u_mode (
    .clk_i,
    .rst_ni,
    .adv_i          (adv),
    .down_i         (s1_mode_q),
    .long_ms_i      (mode_long_q),
    .min_click_ms_i (min_click_q),
    .ev_o           (mode_ev)
  );

  bgc_click u_click (
    .clk_i,
    .rst_ni,
    .adv_i           (adv),
    .pwr_ev_i        (pwr_ev),
    .dbl_window_ms_i (dbl_window_q),
    .double_o        (pdouble),
    .single_o        (psingle)
  );

  assign res_d = {mode_ev.qual, mode_ev.lng, psingle, pdouble,
                  pwr_ev.lng, mode_ev.start, pwr_ev.start};

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  `BGC_NEVER(a_dbl_single_excl, out_valid_q && res_q[3] && res_q[4], "double and single together")
  `BGC_NEVER(a_start_long_excl, out_valid_q && res_q[0] && res_q[2], "press start with long hold")
  `BGC_ASSERT(a_adv_fills_out, adv |=> out_valid_q, "processed item lost before output")
  `BGC_ASSERT(a_full_stalls, (s1_valid_q && !out_ready) |-> !s_axis_tready, "taken while full")

endmodule

// ===== bench/button_gesture_classifier_top_tb.sv =====
module button_gesture_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgc_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES    = 6;

  // Result byte, lowest bit last in the list
  typedef struct packed {
    logic pad;
    logic mode_short;
    logic mode_long;
    logic power_single;
    logic power_double;
    logic power_long;
    logic mode_press_start;
    logic power_press_start;
  } gesture_ev_t;

  // Tracks both buttons tick by tick and holds the gesture events still due
  class gesture_tracker;
    cfg_t        power_long_ms, mode_long_ms, min_click_ms, dbl_window_ms;
    logic        p_held, p_done, m_held, m_done;
    time_t       p_hold, m_hold, since_release;
    logic [1:0]  clicks;
    gesture_ev_t expected_events[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned seen[8];

    function new();
      power_long_ms = POWER_LONG_RST;
      mode_long_ms  = MODE_LONG_RST;
      min_click_ms  = MIN_CLICK_RST;
      dbl_window_ms = DBL_WINDOW_RST;
      p_held = 1'b0;
      p_done = 1'b0;
      m_held = 1'b0;
      m_done = 1'b0;
      p_hold = '0;
      m_hold = '0;
      since_release = '0;
      clicks = '0;
      mismatches = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, cfg_t val);
      case (idx)
        REG_POWER_LONG: power_long_ms = val;
        REG_MODE_LONG:  mode_long_ms  = val;
        REG_MIN_CLICK:  min_click_ms  = val;
        REG_DBL_WINDOW: dbl_window_ms = val;
        default: ;
      endcase
    endfunction

    // Timers stop at all ones
    function time_t bump(time_t t);
      return (t == '1) ? t : t + 1'b1;
    endfunction

    // Advance one button by a tick
    function void advance_button(input logic down, input cfg_t long_ms,
                                 inout logic held, inout logic done, inout time_t hold,
                                 output logic start, output logic lng, output logic qual);
      start = 1'b0;
      lng   = 1'b0;
      qual  = 1'b0;
      if (down && !held) begin
        held  = 1'b1;
        hold  = '0;
        done  = 1'b0;
        start = 1'b1;
      end else if (down) begin
        hold = bump(hold);
        if (!done && hold >= long_ms) begin
          done = 1'b1;
          lng  = 1'b1;
        end
      end else if (held) begin
        held = 1'b0;
        hold = bump(hold);
        if (!done && hold > min_click_ms && hold < long_ms) qual = 1'b1;
      end
    endfunction

    // Note one accepted tick and queue the events it must produce
    function void note_levels(logic pd, logic md);
      gesture_ev_t ev;
      logic        p_qual;
      ev = '0;
      since_release = bump(since_release);
      advance_button(pd, power_long_ms, p_held, p_done, p_hold,
                     ev.power_press_start, ev.power_long, p_qual);
      if (ev.power_long) clicks = '0;
      if (p_qual) begin
        clicks = clicks + 1'b1;
        since_release = '0;
        if (clicks == 2'd2) begin
          clicks = '0;
          ev.power_double = 1'b1;
        end
      end
      advance_button(md, mode_long_ms, m_held, m_done, m_hold,
                     ev.mode_press_start, ev.mode_long, ev.mode_short);
      if (clicks == 2'd1 && since_release > dbl_window_ms) begin
        clicks = '0;
        ev.power_single = 1'b1;
      end
      expected_events.push_back(ev);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        mismatches++;
        $error("%s: expected %0b, got %0b", name, want, got);
      end
    endfunction

    // Check one result transaction against the oldest expected events
    function void check_events(logic [7:0] data);
      gesture_ev_t got, want;
      got = gesture_ev_t'(data);
      checked++;
      if (expected_events.size() == 0) begin
        mismatches++;
        $error("result %b arrived with no events expected", data);
        return;
      end
      want = expected_events.pop_front();
      compare_field("power_press_start", want.power_press_start, got.power_press_start);
      compare_field("mode_press_start", want.mode_press_start, got.mode_press_start);
      compare_field("power_long", want.power_long, got.power_long);
      compare_field("power_double", want.power_double, got.power_double);
      compare_field("power_single", want.power_single, got.power_single);
      compare_field("mode_long", want.mode_long, got.mode_long);
      compare_field("mode_short", want.mode_short, got.mode_short);
      compare_field("pad", want.pad, got.pad);
      for (int b = 0; b < 8; b++) if (got[b] === 1'b1) seen[b]++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] power_down, [1] mode_down
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] power_press_start, [1] mode_press_start, [2] power_long,
  // [3] power_double, [4] power_single, [5] mode_long, [6] mode_short
  logic [7:0]  m_axis_tdata;

  gesture_tracker tracker;
  int unsigned    burst_left;
  int unsigned    items_sent;
  int unsigned    idle_cycles;
  int unsigned    settings_run;
  bit             hold_off_req;

  always #4 clk_i = ~clk_i;

  button_gesture_classifier_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_events(m_axis_tdata);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("button_gesture_classifier_top regression: fail");
      $finish;
    end
  end

  // Result side: switch stall patterns now and then, hold off on request
  initial begin : rx_side
    int unsigned tick;
    int unsigned rx_mode;
    tick = 0;
    rx_mode = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (tick % 256 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= (tick % 5) < 3;
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one tick of button levels; bursts with random gaps between them
  task automatic drive_item(input logic [1:0] lv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 48);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, lv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_levels(lv[0], lv[1]);
    burst_left--;
    items_sent++;
  endtask

  task automatic hold_levels(input logic [1:0] lv, input int unsigned n);
    repeat (n) drive_item(lv);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers on back-to-back edges
  task automatic write_cfg(input cfg_t pl, input cfg_t ml, input cfg_t mc, input cfg_t dw);
    cfg_reg_e regs[4];
    cfg_t     vals[4];
    regs = '{REG_POWER_LONG, REG_MODE_LONG, REG_MIN_CLICK, REG_DBL_WINDOW};
    vals = '{pl, ml, mc, dw};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(regs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // Press length: mostly clicks and long holds around the thresholds
  function automatic int unsigned draw_press(cfg_t min_ms, cfg_t long_ms);
    int unsigned lo, hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = 1;
        hi = 3;
      end
      1, 2, 3, 4, 5: begin
        lo = 32'(min_ms) + 1;
        hi = (long_ms > 1) ? 32'(long_ms) - 1 : 1;
      end
      6, 7, 8: begin
        lo = (long_ms == 0) ? 1 : 32'(long_ms);
        hi = lo + 8;
      end
      default: begin
        lo = 1;
        hi = 2 * 32'(long_ms) + 4;
      end
    endcase
    if (hi < lo) hi = lo;
    if (lo > 100) begin
      lo = 1;
      hi = 80;
    end
    if (hi > lo + 80) hi = lo + 80;
    return $urandom_range(lo, hi);
  endfunction

  // Release length: mostly inside the double-click window, some past it
  function automatic int unsigned draw_release(cfg_t window);
    int unsigned lo, hi;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        lo = 1;
        hi = 32'(window);
      end
      6, 7, 8: begin
        lo = 32'(window) + 1;
        hi = 32'(window) + 20;
      end
      default: begin
        lo = 1;
        hi = 3;
      end
    endcase
    if (hi < lo) hi = lo;
    if (lo > 100) begin
      lo = 1;
      hi = 80;
    end
    if (hi > lo + 80) hi = lo + 80;
    return $urandom_range(lo, hi);
  endfunction

  // Press and release both buttons in shaped runs, with stray ticks mixed in
  task automatic run_gestures(input int unsigned count);
    int unsigned p_left, m_left;
    logic        p_lv, m_lv;
    p_lv = 1'b0;
    m_lv = 1'b0;
    p_left = draw_release(tracker.dbl_window_ms);
    m_left = draw_release(tracker.dbl_window_ms);
    repeat (count) begin
      if (p_left == 0) begin
        p_lv = !p_lv;
        p_left = p_lv ? draw_press(tracker.min_click_ms, tracker.power_long_ms)
                      : draw_release(tracker.dbl_window_ms);
      end
      if (m_left == 0) begin
        m_lv = !m_lv;
        m_left = m_lv ? draw_press(tracker.min_click_ms, tracker.mode_long_ms)
                      : draw_release(tracker.dbl_window_ms);
      end
      if ($urandom_range(0, 24) == 0) begin
        drive_item(2'($urandom_range(0, 3)));
      end else begin
        drive_item({m_lv, p_lv});
      end
      p_left--;
      m_left--;
    end
  endtask

  initial begin : stimulus
    logic [1:0] directed_seq[] = '{
      // power click, then window runs out: single
      2'b01, 2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00,
      // two clicks: double, with a mode short press alongside
      2'b11, 2'b11, 2'b00, 2'b01, 2'b01, 2'b00,
      // both held past their thresholds: long on each
      2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b00,
      // press too short to count
      2'b01, 2'b00
    };
    tracker = new();
    burst_left = 0;
    items_sent = 0;
    settings_run = 1;
    hold_off_req = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_POWER_LONG;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds
    run_gestures(300);
    settle();

    // Directed gestures with tiny thresholds
    write_cfg(16'd4, 16'd3, 16'd1, 16'd3);
    foreach (directed_seq[i]) drive_item(directed_seq[i]);
    settle();

    // Long receiver hold-off while the sender keeps offering
    write_cfg(16'd20, 16'd15, 16'd3, 16'd10);
    hold_off_req = 1'b1;
    run_gestures(300);
    settle();

    // Zero thresholds: long on the first held tick
    write_cfg(16'd0, 16'd0, 16'd0, 16'd0);
    run_gestures(200);
    settle();

    write_cfg(16'd1, 16'd1, 16'd0, 16'd0);
    run_gestures(200);
    settle();

    write_cfg(16'd8, 16'd30, 16'd5, 16'd2);
    run_gestures(300);
    settle();

    write_cfg(16'd40, 16'd40, 16'd10, 16'd30);
    run_gestures(300);
    settle();

    // Largest click minimum and window: no clicks ever qualify
    write_cfg(16'd6, 16'd6, 16'hFFFF, 16'hFFFF);
    run_gestures(200);
    settle();

    // Thresholds at the top of the timer range: holds stay short of long
    write_cfg(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE);
    hold_levels(2'b01, 1);
    hold_levels(2'b00, 1);
    hold_levels(2'b11, 30);
    hold_levels(2'b00, 4);
    settle();

    $display("Sent %0d ticks across %0d threshold settings, directed and random gestures;",
             items_sent, settings_run);
    $display("checked %0d results: starts %0d/%0d, power L/D/S %0d/%0d/%0d, mode L/S %0d/%0d",
             tracker.checked, tracker.seen[0], tracker.seen[1], tracker.seen[2],
             tracker.seen[3], tracker.seen[4], tracker.seen[5], tracker.seen[6]);
    if (tracker.mismatches == 0) begin
      $display("button_gesture_classifier_top regression: pass");
    end else begin
      $display("button_gesture_classifier_top regression: fail");
    end
    $finish;
  end

endmodule
